[hdl/hmm_pkg.sv]
`timescale 1ns / 1ps

package hmm_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

endpackage

[hdl/hmm_if.sv]
`timescale 1ns / 1ps

interface hmm_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [31:0]        key;
  logic signed [31:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface hmm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] removed_count;
  logic [6:0] total_count;

  modport source (output valid, output status, output removed_count,
                  output total_count, input ready);
  modport sink   (input valid, input status, input removed_count,
                  input total_count, output ready);
endinterface

[hdl/hmm_front.sv]
`timescale 1ns / 1ps

module hmm_front #(
  parameter int BUCKETS = 8,
  parameter int RW      = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clearing,
  hmm_in_if.sink             req,
  input  logic               q_full,
  output logic               q_push,
  output hmm_pkg::item_t     q_item,
  output logic [RW-1:0]      q_row
);

  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic                     full;
  logic [2:0]               cnt;
  logic [RW-1:0]            rem;
  logic [RW-1:0]            rem_step;
  logic [hmm_pkg::KEY_W-1:0] key_sh;
  hmm_pkg::item_t           item;
  logic                     done;
  logic                     accept;

  // remainder of one key byte per cycle, msb first
  always_comb begin
    logic [RW:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < 8; i++) begin
      t = {t[RW-1:0], key_sh[hmm_pkg::KEY_W-1-i]};
      if (t >= (RW+1)'(BUCKETS)) begin
        t = t - (RW+1)'(BUCKETS);
      end
    end
    rem_step = t[RW-1:0];
  end

  assign done      = IS_POW2 ? 1'b1 : (cnt == 3'd4);
  assign q_push    = full && done && !q_full;
  assign req.ready = !clearing && (!full || q_push);
  assign accept    = req.valid && req.ready;
  assign q_item    = item;
  assign q_row     = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      if (q_push) begin
        full <= 1'b0;
      end
      if (accept) begin
        full <= 1'b1;
        cnt  <= 3'd0;
      end else if (full && !done) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op    <= hmm_pkg::op_t'(req.op);
      item.key   <= req.key;
      item.value <= req.value;
      key_sh     <= req.key;
      if (IS_POW2 && BUCKETS > 1) begin
        rem <= req.key[RW-1:0];
      end else begin
        rem <= '0;
      end
    end else if (full && !done) begin
      rem    <= rem_step;
      key_sh <= key_sh << 8;
    end
  end

endmodule

[hdl/hmm_fifo.sv]
`timescale 1ns / 1ps

module hmm_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

[hdl/hmm_back.sv]
`timescale 1ns / 1ps

module hmm_back #(
  parameter int BUCKETS = 8,
  parameter int WAYS    = 8,
  parameter int RW      = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  hmm_pkg::item_t  q_item,
  input  logic [RW-1:0]   q_row,
  output logic            q_pop,
  output logic            clearing,
  hmm_out_if.source       rsp
);

  localparam int CW = $clog2(WAYS + 1);
  localparam int TW = $clog2(BUCKETS * WAYS + 1);

  hmm_pkg::back_state_t state, state_next;
  logic [RW-1:0]        clr_row;
  logic [TW-1:0]        entry_total;

  // row store: valid bits, keys and values of one bucket per address
  logic [WAYS-1:0]                          valid_mem [BUCKETS];
  logic [WAYS-1:0][hmm_pkg::KEY_W-1:0]      key_mem   [BUCKETS];
  logic [WAYS-1:0][hmm_pkg::VAL_W-1:0]      val_mem   [BUCKETS];

  logic [WAYS-1:0]                          rd_valid;
  logic [WAYS-1:0][hmm_pkg::KEY_W-1:0]      rd_key;
  logic [WAYS-1:0][hmm_pkg::VAL_W-1:0]      rd_val;

  logic                                     we, re, load;
  logic [RW-1:0]                            wa;
  logic [WAYS-1:0]                          mem_wvalid;

  logic [WAYS-1:0]                          kmatch, dup, free, free_pick;
  logic [CW-1:0]                            removed;
  logic [CW-1:0]                            removed_out;
  logic [WAYS-1:0]                          wvalid;
  logic [WAYS-1:0][hmm_pkg::KEY_W-1:0]      wkey;
  logic [WAYS-1:0][hmm_pkg::VAL_W-1:0]      wval;
  hmm_pkg::status_t                         status;
  logic [TW-1:0]                            total_next;
  logic                                     out_free;

  // compare all ways of the fetched row against the queued item
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      kmatch[w] = rd_valid[w] && (rd_key[w] == q_item.key);
      dup[w]    = kmatch[w] && (rd_val[w] == q_item.value);
      free[w]   = !rd_valid[w];
    end
    free_pick = free & (~free + WAYS'(1));
    removed   = CW'($countones(kmatch));
  end

  always_comb begin
    wvalid      = rd_valid;
    wkey        = rd_key;
    wval        = rd_val;
    total_next  = entry_total;
    removed_out = '0;
    if (q_item.op == hmm_pkg::OP_INSERT) begin
      if (|dup) begin
        status = hmm_pkg::ST_DUP;
      end else if (!(|free)) begin
        status = hmm_pkg::ST_FULL;
      end else begin
        status     = hmm_pkg::ST_ADDED;
        wvalid     = rd_valid | free_pick;
        total_next = entry_total + TW'(1);
        for (int w = 0; w < WAYS; w++) begin
          if (free_pick[w]) begin
            wkey[w] = q_item.key;
            wval[w] = q_item.value;
          end
        end
      end
    end else begin
      wvalid      = rd_valid & ~kmatch;
      total_next  = entry_total - TW'(removed);
      removed_out = removed;
      status      = (removed != '0) ? hmm_pkg::ST_REMOVED : hmm_pkg::ST_NOTFOUND;
    end
  end

  assign out_free   = !rsp.valid || rsp.ready;
  assign clearing   = (state == hmm_pkg::BK_CLEAR);
  assign mem_wvalid = clearing ? '0 : wvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmm_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    re         = 1'b0;
    load       = 1'b0;
    q_pop      = 1'b0;
    wa         = q_row;
    case (state)
      hmm_pkg::BK_CLEAR: begin
        we = 1'b1;
        wa = clr_row;
        if (clr_row == RW'(BUCKETS - 1)) begin
          state_next = hmm_pkg::BK_IDLE;
        end
      end
      hmm_pkg::BK_IDLE: begin
        if (q_valid) begin
          re         = 1'b1;
          state_next = hmm_pkg::BK_EXEC;
        end
      end
      hmm_pkg::BK_EXEC: begin
        if (out_free) begin
          we         = 1'b1;
          load       = 1'b1;
          q_pop      = 1'b1;
          state_next = hmm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = hmm_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row     <= '0;
      entry_total <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + RW'(1);
      end
      if (load) begin
        entry_total <= total_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status        <= status;
      rsp.removed_count <= 4'((32'(removed_out) > 32'd15) ? 32'd15 : 32'(removed_out));
      rsp.total_count   <= 7'((32'(total_next) > 32'd127) ? 32'd127 : 32'(total_next));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      valid_mem[wa] <= mem_wvalid;
      key_mem[wa]   <= wkey;
      val_mem[wa]   <= wval;
    end
    if (re) begin
      rd_valid <= valid_mem[q_row];
      rd_key   <= key_mem[q_row];
      rd_val   <= val_mem[q_row];
    end
  end

endmodule

[hdl/hash_multimap_table_core.sv]
`timescale 1ns / 1ps

// channel | dir | payload                                 | transaction
// req     | in  | op, key[31:0], value[31:0] signed       | valid & ready
// rsp     | out | status[2:0], removed_count[3:0],        | valid & ready
//         |     | total_count[6:0]                        |
//
// After rst, a pass clears each row of the row store in turn; req.ready is low.
// Back end: one row read in BK_IDLE, then compare of all ways plus write-back
// in BK_EXEC. Front end: a power-of-two BUCKETS uses the low key bits as row;
// otherwise the remainder is built eight key bits per cycle.
// The slower end sets the rate. A stalled rsp holds the back end; the two-entry
// queue and the front stage keep taking req transactions until they fill.

module hash_multimap_table_core #(
  parameter int BUCKETS = 8,
  parameter int WAYS    = 8
) (
  input logic        clk,
  input logic        rst,
  hmm_in_if.sink     req,
  hmm_out_if.source  rsp
);

  localparam int RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = hmm_pkg::ITEM_W + RW;

  logic               clearing;
  logic               q_push, q_pop, q_full, q_empty;
  hmm_pkg::item_t     f_item, b_item;
  logic [RW-1:0]      f_row, b_row;
  logic [QW-1:0]      q_din, q_dout;

  // front: accept and compute the bucket row
  hmm_front #(
    .BUCKETS (BUCKETS),
    .RW      (RW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .req      (req),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (f_item),
    .q_row    (f_row)
  );

  assign q_din = {f_item, f_row};

  // decoupling queue between front and back
  hmm_fifo #(
    .W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_item = hmm_pkg::item_t'(q_dout[QW-1:RW]);
  assign b_row  = q_dout[RW-1:0];

  // back: read-modify-write of one bucket row per transaction
  hmm_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .RW      (RW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!q_empty),
    .q_item   (b_item),
    .q_row    (b_row),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

  // queue never popped while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue underflow");

  // no transaction taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request accepted during clear");

  // a pop always loads a fresh result into the output register
  a_pop_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> rsp.valid)
    else $error("pop without result");

endmodule
